// ===== hw/rtl/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants for the sparse set table: operation and status
// codes, sequencer state encoding and the store write-enable group.
// ----------------------------------------------------------------------------
package sst_pkg;

   // default sizes
   localparam int SST_MAX_ENTITIES  = 1024;
   localparam int SST_CAPACITY      = 256;
   localparam int SST_PAYLOAD_WIDTH = 32;

   // fixed field widths of the transaction
   localparam int OP_W     = 2;
   localparam int ENTITY_W = 10;
   localparam int PAYIN_W  = 32;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 8;
   localparam int PAYOUT_W = 32;
   localparam int COUNT_W  = 9;

   // operation codes
   localparam logic [OP_W-1:0] OP_INSERT     = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT_DEF = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE     = 2'd2;
   localparam logic [OP_W-1:0] OP_LOOKUP     = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

   // sequencer states, one-hot
   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_LOOK  = 7'b0000100,
      S_READ  = 7'b0001000,
      S_MOVE  = 7'b0010000,
      S_FIX   = 7'b0100000,
      S_DONE  = 7'b1000000
   } sst_state_type;

   // write strobes toward the table store
   typedef struct packed {
      logic sparse_we;
      logic owner_we;
      logic pay_we;
   } sst_we_type;

endpackage

// ===== hw/rtl/sst_store.sv =====
// ----------------------------------------------------------------------------
// sst_store
// Table storage: sparse map, dense owner and dense payload memories, each
// with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sst_store #(
   parameter int MAX_ENTITIES  = sst_pkg::SST_MAX_ENTITIES,
   parameter int CAPACITY      = sst_pkg::SST_CAPACITY,
   parameter int PAYLOAD_WIDTH = sst_pkg::SST_PAYLOAD_WIDTH,
   parameter int EW            = $clog2(MAX_ENTITIES),
   parameter int SW            = $clog2(CAPACITY),
   parameter int MW            = SW + 1
) (
   input  logic                     clock,
   input  sst_pkg::sst_we_type      we,
   input  logic [EW-1:0]            sparse_rd_addr,
   input  logic [EW-1:0]            sparse_wr_addr,
   input  logic [MW-1:0]            sparse_wr_data,
   output logic [MW-1:0]            sparse_rdata,
   input  logic [SW-1:0]            owner_rd_addr,
   input  logic [SW-1:0]            owner_wr_addr,
   input  logic [EW-1:0]            owner_wr_data,
   output logic [EW-1:0]            owner_rdata,
   input  logic [SW-1:0]            pay_rd_addr,
   input  logic [SW-1:0]            pay_wr_addr,
   input  logic [PAYLOAD_WIDTH-1:0] pay_wr_data,
   output logic [PAYLOAD_WIDTH-1:0] pay_rdata
);
   import sst_pkg::*;

   logic [MW-1:0]            sparse_mem [0:MAX_ENTITIES-1];
   logic [EW-1:0]            owner_mem  [0:CAPACITY-1];
   logic [PAYLOAD_WIDTH-1:0] pay_mem    [0:CAPACITY-1];

   logic [MW-1:0]            sparse_rd_ff;
   logic [EW-1:0]            owner_rd_ff;
   logic [PAYLOAD_WIDTH-1:0] pay_rd_ff;

   // sparse map
   always_ff @(posedge clock) begin
      if (we.sparse_we) begin
         sparse_mem[sparse_wr_addr] <= sparse_wr_data;
      end
      sparse_rd_ff <= sparse_mem[sparse_rd_addr];
   end

   // dense owner
   always_ff @(posedge clock) begin
      if (we.owner_we) begin
         owner_mem[owner_wr_addr] <= owner_wr_data;
      end
      owner_rd_ff <= owner_mem[owner_rd_addr];
   end

   // dense payload
   always_ff @(posedge clock) begin
      if (we.pay_we) begin
         pay_mem[pay_wr_addr] <= pay_wr_data;
      end
      pay_rd_ff <= pay_mem[pay_rd_addr];
   end

   assign sparse_rdata = sparse_rd_ff;
   assign owner_rdata  = owner_rd_ff;
   assign pay_rdata    = pay_rd_ff;

endmodule

// ===== hw/rtl/sst_seq.sv =====
// ----------------------------------------------------------------------------
// sst_seq
// Operation sequencer: clears the sparse map after reset, then walks each
// transaction through lookup, payload read, swap-remove and result stages
// as its operation needs, with compare logic on the slot, entity and count.
// ----------------------------------------------------------------------------
module sst_seq #(
   parameter int MAX_ENTITIES  = sst_pkg::SST_MAX_ENTITIES,
   parameter int CAPACITY      = sst_pkg::SST_CAPACITY,
   parameter int PAYLOAD_WIDTH = sst_pkg::SST_PAYLOAD_WIDTH,
   parameter int EW            = $clog2(MAX_ENTITIES),
   parameter int SW            = $clog2(CAPACITY),
   parameter int MW            = SW + 1,
   parameter int CW            = $clog2(CAPACITY + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   // request side
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [sst_pkg::OP_W-1:0]      req_op,
   input  logic [sst_pkg::ENTITY_W-1:0]  req_entity,
   input  logic [sst_pkg::PAYIN_W-1:0]   req_payload,
   // response side
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sst_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_found,
   output logic [sst_pkg::SLOT_W-1:0]    rsp_slot,
   output logic [sst_pkg::PAYOUT_W-1:0]  rsp_payload,
   output logic [sst_pkg::COUNT_W-1:0]   rsp_count,
   // store access
   output sst_pkg::sst_we_type           we,
   output logic [EW-1:0]                 sparse_rd_addr,
   output logic [EW-1:0]                 sparse_wr_addr,
   output logic [MW-1:0]                 sparse_wr_data,
   input  logic [MW-1:0]                 sparse_rdata,
   output logic [SW-1:0]                 owner_rd_addr,
   output logic [SW-1:0]                 owner_wr_addr,
   output logic [EW-1:0]                 owner_wr_data,
   input  logic [EW-1:0]                 owner_rdata,
   output logic [SW-1:0]                 pay_rd_addr,
   output logic [SW-1:0]                 pay_wr_addr,
   output logic [PAYLOAD_WIDTH-1:0]      pay_wr_data,
   input  logic [PAYLOAD_WIDTH-1:0]      pay_rdata
);
   import sst_pkg::*;

   localparam logic [MW-1:0] SLOT_INV = {MW{1'b1}};
   localparam logic [EW-1:0] CLR_LAST = EW'(MAX_ENTITIES - 1);
   localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);

   sst_state_type            state_ff, state_in;
   logic [EW-1:0]            clr_ff, clr_in;
   logic [OP_W-1:0]          op_ff, op_in;
   logic [ENTITY_W-1:0]      ent_ff, ent_in;
   logic [PAYLOAD_WIDTH-1:0] pay_ff, pay_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [SW-1:0]            slot_ff, slot_in;
   logic                     found_ff, found_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic [PAYLOAD_WIDTH-1:0] pout_ff, pout_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [SLOT_W-1:0]        rsp_slot_ff, rsp_slot_in;
   logic [PAYOUT_W-1:0]      rsp_payload_ff, rsp_payload_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;

   logic                     accept;
   logic                     in_range;
   logic                     hit;
   logic                     full;
   logic [EW-1:0]            ent_addr;
   logic [SW-1:0]            last_slot;
   logic [PAYLOAD_WIDTH-1:0] ins_value;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // compare logic: slot against live count, entity against table size, count against capacity
   assign ent_addr  = EW'(ent_ff);
   assign in_range  = (32'(ent_ff) < 32'(MAX_ENTITIES));
   assign hit       = in_range && (sparse_rdata < MW'(count_ff));
   assign full      = (count_ff == CAP_CNT);
   assign last_slot = SW'(count_ff - CW'(1));
   assign ins_value = (op_ff == OP_INSERT) ? pay_ff : '0;

   // read addresses
   assign sparse_rd_addr = (state_ff == S_IDLE) ? EW'(req_entity) : ent_addr;
   assign owner_rd_addr  = last_slot;
   assign pay_rd_addr    = (state_ff == S_LOOK) ? sparse_rdata[SW-1:0] : last_slot;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      op_in          = op_ff;
      ent_in         = ent_ff;
      pay_in         = pay_ff;
      count_in       = count_ff;
      slot_in        = slot_ff;
      found_in       = found_ff;
      status_in      = status_ff;
      pout_in        = pout_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_count_in   = rsp_count_ff;
      we             = '0;
      sparse_wr_addr = ent_addr;
      sparse_wr_data = SLOT_INV;
      owner_wr_addr  = slot_ff;
      owner_wr_data  = owner_rdata;
      pay_wr_addr    = slot_ff;
      pay_wr_data    = pay_rdata;

      case (state_ff)
         S_CLEAR: begin
            // mark every sparse entry invalid, one per cycle
            we.sparse_we   = 1'b1;
            sparse_wr_addr = clr_ff;
            clr_in         = clr_ff + EW'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in    = req_op;
               ent_in   = req_entity;
               pay_in   = PAYLOAD_WIDTH'(req_payload);
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            // sparse entry is back: decide the operation's path
            found_in  = hit;
            slot_in   = hit ? sparse_rdata[SW-1:0] : '0;
            pout_in   = '0;
            status_in = ST_OK;
            state_in  = S_DONE;
            case (op_ff)
               OP_INSERT, OP_INSERT_DEF: begin
                  if (hit) begin
                     status_in = ST_PRESENT;
                     state_in  = S_READ;
                  end else if (!in_range || full) begin
                     status_in = ST_FULL;
                  end else begin
                     // append at the end of the dense array
                     we             = '{sparse_we: 1'b1, owner_we: 1'b1, pay_we: 1'b1};
                     sparse_wr_data = MW'(count_ff);
                     owner_wr_addr  = SW'(count_ff);
                     owner_wr_data  = ent_addr;
                     pay_wr_addr    = SW'(count_ff);
                     pay_wr_data    = ins_value;
                     slot_in        = SW'(count_ff);
                     pout_in        = ins_value;
                     count_in       = count_ff + CW'(1);
                  end
               end
               default: begin
                  // remove and lookup
                  if (hit) begin
                     state_in = S_READ;
                  end else begin
                     status_in = ST_ABSENT;
                  end
               end
            endcase
         end
         S_READ: begin
            // payload of the found slot; remove also fetches the last entry
            pout_in  = pay_rdata;
            state_in = (op_ff == OP_REMOVE) ? S_MOVE : S_DONE;
         end
         S_MOVE: begin
            // last entry into the freed slot, repoint its sparse entry
            if (slot_ff != last_slot) begin
               we             = '{sparse_we: 1'b1, owner_we: 1'b1, pay_we: 1'b1};
               sparse_wr_addr = owner_rdata;
               sparse_wr_data = MW'(slot_ff);
            end
            state_in = S_FIX;
         end
         S_FIX: begin
            we.sparse_we = 1'b1;
            count_in     = count_ff - CW'(1);
            state_in     = S_DONE;
         end
         S_DONE: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_found_in   = found_ff;
               rsp_slot_in    = SLOT_W'(slot_ff);
               rsp_payload_in = PAYOUT_W'(pout_ff);
               rsp_count_in   = COUNT_W'(count_ff);
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      ent_ff         <= ent_in;
      pay_ff         <= pay_in;
      slot_ff        <= slot_in;
      found_ff       <= found_in;
      status_ff      <= status_in;
      pout_ff        <= pout_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_found   = rsp_found_ff;
   assign rsp_slot    = rsp_slot_ff;
   assign rsp_payload = rsp_payload_ff;
   assign rsp_count   = rsp_count_ff;

endmodule

// ===== hw/rtl/sparse_set_table_top.sv =====
// ----------------------------------------------------------------------------
// sparse_set_table_top
// Sparse set mapping entity indices to packed dense slots with payloads.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one operation per transaction: tuser holds the
//   operation (insert, default insert, remove, lookup), tdata the entity
//   index and the payload word. rsp channel returns exactly one result per
//   request: status, found flag, dense slot, payload and entry count.
//   One request is in flight at a time; req_tready is high only while the
//   sequencer waits. Each operation walks a chain of registered reads of
//   the sparse, owner and payload memories: a new insert or a miss reads
//   the sparse map only, a hit lookup or duplicate insert also the payload,
//   and a remove that hits also moves the last entry into the freed slot.
//   After reset the sparse map is cleared one entry per cycle, all
//   MAX_ENTITIES entries (1024 at defaults), with req_tready low.
//   The result sits in an output register; a new request is accepted while
//   it waits, and the sequencer holds its next result until rsp_tready.
// ----------------------------------------------------------------------------
module sparse_set_table_top #(
   parameter int MAX_ENTITIES  = sst_pkg::SST_MAX_ENTITIES,
   parameter int CAPACITY      = sst_pkg::SST_CAPACITY,
   parameter int PAYLOAD_WIDTH = sst_pkg::SST_PAYLOAD_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [9:0] entity_index, [41:10] payload_in, [47:42] zero
   input  logic [47:0] req_tdata,
   // [1:0] operation
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] status, [2] found, [10:3] dense_slot, [42:11] payload_out,
   // [51:43] entry_count, [55:52] zero
   output logic [55:0] rsp_tdata
);
   import sst_pkg::*;

   localparam int EW = $clog2(MAX_ENTITIES);
   localparam int SW = $clog2(CAPACITY);
   localparam int MW = SW + 1;

   sst_we_type               we;
   logic [EW-1:0]            sparse_rd_addr, sparse_wr_addr;
   logic [MW-1:0]            sparse_wr_data, sparse_rdata;
   logic [SW-1:0]            owner_rd_addr, owner_wr_addr;
   logic [EW-1:0]            owner_wr_data, owner_rdata;
   logic [SW-1:0]            pay_rd_addr, pay_wr_addr;
   logic [PAYLOAD_WIDTH-1:0] pay_wr_data, pay_rdata;

   logic [STATUS_W-1:0]      rsp_status;
   logic                     rsp_found;
   logic [SLOT_W-1:0]        rsp_slot;
   logic [PAYOUT_W-1:0]      rsp_payload;
   logic [COUNT_W-1:0]       rsp_count;

   // sequencer
   sst_seq #(
      .MAX_ENTITIES  (MAX_ENTITIES),
      .CAPACITY      (CAPACITY),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_op         (req_tuser),
      .req_entity     (req_tdata[9:0]),
      .req_payload    (req_tdata[41:10]),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_status     (rsp_status),
      .rsp_found      (rsp_found),
      .rsp_slot       (rsp_slot),
      .rsp_payload    (rsp_payload),
      .rsp_count      (rsp_count),
      .we             (we),
      .sparse_rd_addr (sparse_rd_addr),
      .sparse_wr_addr (sparse_wr_addr),
      .sparse_wr_data (sparse_wr_data),
      .sparse_rdata   (sparse_rdata),
      .owner_rd_addr  (owner_rd_addr),
      .owner_wr_addr  (owner_wr_addr),
      .owner_wr_data  (owner_wr_data),
      .owner_rdata    (owner_rdata),
      .pay_rd_addr    (pay_rd_addr),
      .pay_wr_addr    (pay_wr_addr),
      .pay_wr_data    (pay_wr_data),
      .pay_rdata      (pay_rdata)
   );

   // table memories
   sst_store #(
      .MAX_ENTITIES  (MAX_ENTITIES),
      .CAPACITY      (CAPACITY),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
   ) u_store (
      .clock          (clock),
      .we             (we),
      .sparse_rd_addr (sparse_rd_addr),
      .sparse_wr_addr (sparse_wr_addr),
      .sparse_wr_data (sparse_wr_data),
      .sparse_rdata   (sparse_rdata),
      .owner_rd_addr  (owner_rd_addr),
      .owner_wr_addr  (owner_wr_addr),
      .owner_wr_data  (owner_wr_data),
      .owner_rdata    (owner_rdata),
      .pay_rd_addr    (pay_rd_addr),
      .pay_wr_addr    (pay_wr_addr),
      .pay_wr_data    (pay_wr_data),
      .pay_rdata      (pay_rdata)
   );

   // response packing
   assign rsp_tdata = {4'b0000, rsp_count, rsp_payload, rsp_slot, rsp_found, rsp_status};

endmodule

// ===== test/sparse_set_table_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_set_table_top_test
// Self-checking bench for the sparse set table. A short table of directed
// operations runs first. Random traffic follows: fills to capacity, drains,
// and mixes of insert, remove and lookup. Every result is compared with a
// shadow copy of the sparse map and the dense stores, or with the result of a typed row.
// ----------------------------------------------------------------------------
module sparse_set_table_top_test;
   import sst_pkg::*;

   // cycles without any accepted transaction before the run is abandoned;
   // the clearing pass after reset fits with margin
   localparam int QUIET_LIMIT = 5000;
   localparam int unsigned NO_SLOT = 32'hFFFF_FFFF;
   localparam int DIRECTED_ROWS = 24;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                found;
      logic [SLOT_W-1:0]   slot;
      logic [PAYOUT_W-1:0] payload;
      logic [COUNT_W-1:0]  count;
   } table_result_type;

   typedef struct {
      logic [OP_W-1:0]     op;
      logic [ENTITY_W-1:0] ent;
      logic [PAYIN_W-1:0]  pay;
      bit                  typed;
      table_result_type    want;
   } directed_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;

   // shadow of the table
   int unsigned     entity_slot  [SST_MAX_ENTITIES];
   logic [9:0]      slot_owner   [SST_CAPACITY];
   logic [31:0]     slot_payload [SST_CAPACITY];
   int unsigned     live_entries;
   int unsigned     peak_entries;

   table_result_type expected_results [$];
   int unsigned     sender_idle_pct;
   int unsigned     receiver_stall_pct;
   int unsigned     items_sent;
   int unsigned     results_seen;
   int unsigned     mismatches;
   int unsigned     quiet_cycles;
   int unsigned     status_tally [4];

   // directed operations; typed rows carry their result, the rest use the shadow
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{OP_LOOKUP,     10'd0,    32'h0000_0000, 1'b1, {ST_ABSENT,  1'b0, 8'd0, 32'h0, 9'd0}},
      '{OP_REMOVE,     10'd1023, 32'h0000_0000, 1'b1, {ST_ABSENT,  1'b0, 8'd0, 32'h0, 9'd0}},
      '{OP_INSERT,     10'd0,    32'hFFFF_FFFF, 1'b1,
        {ST_OK,      1'b0, 8'd0, 32'hFFFF_FFFF, 9'd1}},
      '{OP_INSERT,     10'd1023, 32'h0000_0000, 1'b1, {ST_OK,      1'b0, 8'd1, 32'h0, 9'd2}},
      '{OP_INSERT_DEF, 10'd512,  32'hA5A5_A5A5, 1'b1, {ST_OK,      1'b0, 8'd2, 32'h0, 9'd3}},
      '{OP_INSERT,     10'd0,    32'h1234_5678, 1'b1,
        {ST_PRESENT, 1'b1, 8'd0, 32'hFFFF_FFFF, 9'd3}},
      '{OP_INSERT_DEF, 10'd1023, 32'hFFFF_0000, 1'b1, {ST_PRESENT, 1'b1, 8'd1, 32'h0, 9'd3}},
      '{OP_LOOKUP,     10'd512,  32'h0000_0000, 1'b1, {ST_OK,      1'b1, 8'd2, 32'h0, 9'd3}},
      '{OP_LOOKUP,     10'd1023, 32'h0000_0000, 1'b1, {ST_OK,      1'b1, 8'd1, 32'h0, 9'd3}},
      '{OP_REMOVE,     10'd0,    32'h0000_0000, 1'b1,
        {ST_OK,      1'b1, 8'd0, 32'hFFFF_FFFF, 9'd2}},
      '{OP_LOOKUP,     10'd512,  32'h0000_0000, 1'b0, '0},
      '{OP_LOOKUP,     10'd0,    32'h0000_0000, 1'b1, {ST_ABSENT,  1'b0, 8'd0, 32'h0, 9'd2}},
      '{OP_REMOVE,     10'd1023, 32'h0000_0000, 1'b0, '0},
      '{OP_REMOVE,     10'd1023, 32'h0000_0000, 1'b1, {ST_ABSENT,  1'b0, 8'd0, 32'h0, 9'd1}},
      '{OP_INSERT,     10'd341,  32'h5555_5555, 1'b0, '0},
      '{OP_INSERT,     10'd682,  32'hAAAA_AAAA, 1'b0, '0},
      '{OP_REMOVE,     10'd512,  32'h0000_0000, 1'b0, '0},
      '{OP_LOOKUP,     10'd682,  32'h0000_0000, 1'b0, '0},
      '{OP_LOOKUP,     10'd341,  32'h0000_0000, 1'b0, '0},
      '{OP_REMOVE,     10'd341,  32'h0000_0000, 1'b0, '0},
      '{OP_REMOVE,     10'd682,  32'h0000_0000, 1'b0, '0},
      '{OP_INSERT_DEF, 10'd1,    32'h0F0F_0F0F, 1'b0, '0},
      '{OP_REMOVE,     10'd1,    32'h0000_0000, 1'b0, '0},
      '{OP_LOOKUP,     10'd1,    32'h0000_0000, 1'b1, {ST_ABSENT,  1'b0, 8'd0, 32'h0, 9'd0}}
   };

   sparse_set_table_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // slot owned by an entity, or NO_SLOT
   function automatic int unsigned find_slot(input logic [9:0] ent);
      int unsigned s;
      if (int'(ent) >= SST_MAX_ENTITIES) return NO_SLOT;
      s = entity_slot[ent];
      if (s >= live_entries || s >= SST_CAPACITY) return NO_SLOT;
      return s;
   endfunction

   // apply one operation to the shadow table and return its result
   function automatic table_result_type apply_table_op(input logic [1:0] op,
                                                       input logic [9:0] ent,
                                                       input logic [31:0] pay);
      table_result_type r;
      int unsigned   s;
      int unsigned   last;
      logic [9:0]    mover;
      r = '0;
      r.status = ST_OK;
      s = find_slot(ent);
      if (s != NO_SLOT) begin
         r.found   = 1'b1;
         r.slot    = s[7:0];
         r.payload = slot_payload[s];
      end
      case (op)
         OP_INSERT, OP_INSERT_DEF: begin
            if (r.found) begin
               r.status = ST_PRESENT;
            end else if (int'(ent) >= SST_MAX_ENTITIES || live_entries >= SST_CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               // append at the end of the dense stores
               r.slot    = live_entries[7:0];
               r.payload = (op == OP_INSERT) ? pay : '0;
               entity_slot[ent]           = live_entries;
               slot_owner[live_entries]   = ent;
               slot_payload[live_entries] = r.payload;
               live_entries++;
            end
         end
         OP_REMOVE: begin
            if (!r.found) begin
               r.status = ST_ABSENT;
            end else begin
               // swap the last entry into the freed slot
               last = live_entries - 1;
               if (s != last) begin
                  mover             = slot_owner[last];
                  slot_owner[s]     = mover;
                  slot_payload[s]   = slot_payload[last];
                  entity_slot[mover] = s;
               end
               entity_slot[ent] = NO_SLOT;
               live_entries     = last;
            end
         end
         default: begin
            if (!r.found) r.status = ST_ABSENT;
         end
      endcase
      r.count = live_entries[8:0];
      if (live_entries > peak_entries) peak_entries = live_entries;
      return r;
   endfunction

   function automatic logic [9:0] live_entity();
      return slot_owner[$urandom_range(live_entries - 1)];
   endfunction

   function automatic logic [9:0] fresh_entity();
      logic [9:0] e;
      do e = 10'($urandom); while (find_slot(e) != NO_SLOT);
      return e;
   endfunction

   function automatic logic [1:0] insert_kind();
      return ($urandom_range(9) < 7) ? OP_INSERT : OP_INSERT_DEF;
   endfunction

   // present one request, wait for its acceptance, record what it must return
   task automatic send_op(input logic [1:0] op, input logic [9:0] ent,
                          input logic [31:0] pay, input bit typed,
                          input table_result_type want);
      table_result_type predicted;
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'd0, pay, ent};
      do @(posedge clock); while (!req_tready);
      predicted = apply_table_op(op, ent, pay);
      if (typed) predicted = want;
      expected_results.push_back(predicted);
      status_tally[predicted.status]++;
      items_sent++;
   endtask

   // random traffic; percentages pick insert and remove, the rest are lookups
   task automatic run_mix(input int unsigned n, input int unsigned ins_pct,
                          input int unsigned rem_pct);
      logic [1:0]  op;
      logic [9:0]  ent;
      int unsigned roll;
      repeat (n) begin
         roll = $urandom_range(99);
         if (roll < ins_pct) begin
            op  = insert_kind();
            ent = (live_entries > 0 && $urandom_range(99) < 15) ? live_entity()
                                                                : 10'($urandom);
         end else begin
            op  = (roll < ins_pct + rem_pct) ? OP_REMOVE : OP_LOOKUP;
            ent = (live_entries > 0 && $urandom_range(99) < 65) ? live_entity()
                                                                : 10'($urandom);
         end
         send_op(op, ent, $urandom, 1'b0, '0);
      end
   endtask

   // fill to capacity, hit the full table with new and duplicate inserts and lookups, then remove and refill
   task automatic run_fill();
      while (live_entries < SST_CAPACITY)
         send_op(insert_kind(), fresh_entity(), $urandom, 1'b0, '0);
      repeat (6) send_op(insert_kind(), fresh_entity(), $urandom, 1'b0, '0);
      repeat (4) send_op(insert_kind(), live_entity(), $urandom, 1'b0, '0);
      repeat (4) send_op(OP_LOOKUP, live_entity(), $urandom, 1'b0, '0);
      repeat (2) begin
         send_op(OP_REMOVE, live_entity(), $urandom, 1'b0, '0);
         send_op(insert_kind(), fresh_entity(), $urandom, 1'b0, '0);
      end
   endtask

   // compare one accepted result with the oldest expectation
   task automatic check_result(input logic [55:0] data);
      table_result_type got;
      table_result_type want;
      got = {data[1:0], data[2], data[10:3], data[42:11], data[51:43]};
      results_seen++;
      if (expected_results.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("[%0t] result with nothing expected: status %0d found %0d slot %0d",
                     $realtime, got.status, got.found, got.slot);
      end else begin
         want = expected_results.pop_front();
         if (got.status !== want.status || got.found !== want.found ||
             got.slot !== want.slot || got.payload !== want.payload ||
             got.count !== want.count) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("[%0t] result %0d: expected status %0d found %0d slot %0d pay %h cnt %0d",
                        $realtime, results_seen, want.status, want.found, want.slot,
                        want.payload, want.count);
               $display("          got      status %0d found %0d slot %0d pay %h cnt %0d",
                        got.status, got.found, got.slot, got.payload, got.count);
            end
         end
      end
   endtask

   // result side: check transactions, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // watchdog on cycles without progress on either channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", quiet_cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // stimulus
   initial begin
      for (int i = 0; i < SST_MAX_ENTITIES; i++) entity_slot[i] = NO_SLOT;
      live_entries       = 0;
      peak_entries       = 0;
      items_sent         = 0;
      results_seen       = 0;
      mismatches         = 0;
      quiet_cycles       = 0;
      status_tally       = '{default: 0};
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1:       begin sender_idle_pct = 52; receiver_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  receiver_stall_pct = 52; end
            default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
         endcase
         if (phase == 0) begin
            foreach (directed_rows[i])
               send_op(directed_rows[i].op, directed_rows[i].ent, directed_rows[i].pay,
                       directed_rows[i].typed, directed_rows[i].want);
         end
         if (phase == 0 || phase == 3) begin
            run_fill();
            run_mix(160, 20, 60);
            run_mix(60, 45, 30);
         end else begin
            run_mix(450, 45, 30);
         end
      end
      req_tvalid <= 1'b0;

      // drain outstanding results, then watch for stray ones
      while (expected_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("%0d requests, %0d results; ok %0d, already present %0d, absent %0d, full %0d",
               items_sent, results_seen, status_tally[ST_OK], status_tally[ST_PRESENT],
               status_tally[ST_ABSENT], status_tally[ST_FULL]);
      $display("peak entry count %0d of %0d, %0d mismatches", peak_entries, SST_CAPACITY,
               mismatches);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/sst_pkg.sv
hw/rtl/sst_store.sv
hw/rtl/sst_seq.sv
hw/rtl/sparse_set_table_top.sv
test/sparse_set_table_top_test.sv
